/* rtl/wheel_pulse_speedometer_defines.svh */
// Assertion macros for the wheel pulse speedometer.
// Used by the controller and datapath; expects clock and reset in scope.
`ifndef WHEEL_PULSE_SPEEDOMETER_DEFINES_SVH
`define WHEEL_PULSE_SPEEDOMETER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define WPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wps_pkg.sv */
// Shared types and constants of the wheel pulse speedometer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

   typedef enum logic [1:0] {
      FUNC_RISE = 2'd0,
      FUNC_FALL = 2'd1,
      FUNC_POLL = 2'd2
   } func_type;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_CIRC     = 2'd0;
   localparam logic [1:0] REG_WINDOW   = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE = 2'd2;

   localparam logic [15:0] CIRC_RESET     = 16'd2100;
   localparam logic [15:0] WINDOW_RESET   = 16'd3000;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [31:0] MM_PER_M      = 32'd1000;

   // reciprocals of 1000: scale 2^38 for a 32-bit dividend, 2^36 for a 26-bit one
   localparam logic [28:0] KILO_RECIP = 29'd274877907;
   localparam logic [26:0] FRAC_RECIP = 27'd68719477;

   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_BITS_SPEED = 6'd28;
   localparam logic [DIV_CNT_W-1:0] DIV_BITS_AVG   = 6'd60;

   typedef enum logic [1:0] {
      DIV_SPEED,
      DIV_AVG
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PULSE,
      ST_CALC,
      ST_MUL,
      ST_SPD_LOAD,
      ST_SPD_RUN,
      ST_DST_LOW,
      ST_DST_SCALE,
      ST_DST_SUM,
      ST_AVG_LOAD,
      ST_AVG_RUN,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic [15:0] circ;
      logic [15:0] window;
      logic [15:0] debounce;
   } cfg_type;

   typedef struct packed {
      logic       take;
      logic       pulse;
      logic       calc;
      logic       mul;
      logic       dst_low;
      logic       dst_scale;
      logic       dst_sum;
      logic       div_load;
      logic       div_step;
      logic       div_capture;
      div_op_type div_op;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   typedef struct packed {
      logic [27:0] speed_m_per_h;
      logic [31:0] ride_time_ms;
      logic [31:0] distance_m;
      logic [31:0] average_speed;
      logic [31:0] revolutions;
   } rsp_data_type;

endpackage

`default_nettype wire

/* rtl/wps_if.sv */
// Channel interfaces of the wheel pulse speedometer: event input and result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] now_ms;
   logic        button_level;

   modport source (output valid, output func, output now_ms, output button_level,
                   input ready);
   modport sink   (input valid, input func, input now_ms, input button_level,
                   output ready);
endinterface

interface wps_rsp_if;
   logic        valid;
   logic        ready;
   logic [27:0] speed_m_per_h;
   logic [31:0] ride_time_ms;
   logic [31:0] distance_m;
   logic [31:0] average_speed;
   logic [31:0] revolutions;

   modport source (output valid, output speed_m_per_h, output ride_time_ms,
                   output distance_m, output average_speed, output revolutions,
                   input ready);
   modport sink   (input valid, input speed_m_per_h, input ride_time_ms,
                   input distance_m, input average_speed, input revolutions,
                   output ready);
endinterface

`default_nettype wire

/* rtl/wps_csr.sv */
// APB-style configuration registers of the wheel pulse speedometer.
// Depends on wps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wps_csr
   import wps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready,
   output      cfg_type               cfg
);

   logic [15:0] circ_ff, circ_in;
   logic [15:0] window_ff, window_in;
   logic [15:0] debounce_ff, debounce_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      circ_in     = circ_ff;
      window_in   = window_ff;
      debounce_in = debounce_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_CIRC:     circ_in     = pwdata[15:0];
            REG_WINDOW:   window_in   = pwdata[15:0];
            REG_DEBOUNCE: debounce_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CIRC:     prdata = {16'b0, circ_ff};
         REG_WINDOW:   prdata = {16'b0, window_ff};
         REG_DEBOUNCE: prdata = {16'b0, debounce_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff     <= CIRC_RESET;
         window_ff   <= WINDOW_RESET;
         debounce_ff <= DEBOUNCE_RESET;
      end else begin
         circ_ff     <= circ_in;
         window_ff   <= window_in;
         debounce_ff <= debounce_in;
      end
   end

   assign cfg = '{circ: circ_ff, window: window_ff, debounce: debounce_ff};

endmodule

`default_nettype wire

/* rtl/wps_dp.sv */
// Datapath of the wheel pulse speedometer: event state, multipliers,
// shared bit-serial divider and result register. Depends on wps_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_pulse_speedometer_defines.svh"

module wps_dp
   import wps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire cfg_type      cfg,
   input  wire logic [1:0]   func,
   input  wire logic [31:0]  now_ms,
   input  wire logic         button_level,
   output      status_type   status,
   output      rsp_data_type rsp_data
);

   logic [31:0] ltt_ff, ltt_in;
   logic [31:0] let_ff, let_in;
   logic [31:0] lpt_ff, lpt_in;
   logic [31:0] rt_ff, rt_in;
   logic [31:0] ride_ff, ride_in;
   logic [31:0] count_ff, count_in;
   logic        held_ff, held_in;

   logic [31:0] now_ff, now_in;
   logic [15:0] delta_ff, delta_in;
   logic        speed_ok_ff, speed_ok_in;
   logic [27:0] prod_speed_ff, prod_speed_in;
   logic [59:0] scaled_ff, scaled_in;

   logic [22:0] kilo_ff, kilo_in;
   logic [9:0]  kilo_rem_ff, kilo_rem_in;
   logic [31:0] dist_hi_ff, dist_hi_in;
   logic [25:0] frac_prod_ff, frac_prod_in;
   logic [16:0] frac_ff, frac_in;

   logic [31:0]          rem_ff, rem_in;
   logic [63:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          divisor_ff, divisor_in;

   logic [27:0] speed_res_ff, speed_res_in;
   logic [31:0] dist_res_ff, dist_res_in;
   logic [31:0] avg_res_ff, avg_res_in;
   rsp_data_type rsp_ff, rsp_in;

   logic        rise;
   logic [31:0] since_trans;
   logic [31:0] rev_span;
   logic [31:0] idle;
   logic [31:0] delta;
   logic [32:0] trial;
   logic [32:0] diff;
   logic [60:0] kilo_full;
   logic [31:0] kilo_back;
   logic [31:0] kilo_left;
   logic [38:0] hi_full;
   logic [52:0] frac_full;

   assign since_trans = now_ms - ltt_ff;
   assign rev_span    = let_ff - lpt_ff;
   assign idle        = now_ff - lpt_ff;
   assign delta       = (idle > rt_ff) ? idle : rt_ff;
   assign trial       = {rem_ff, quo_ff[63]};
   assign diff        = trial - {1'b0, divisor_ff};

   // distance: circ * (1000 * kilo + rem) / 1000 = circ * kilo + circ * rem / 1000
   assign kilo_full = count_ff * KILO_RECIP;
   assign kilo_back = {9'd0, kilo_ff} * MM_PER_M;
   assign kilo_left = count_ff - kilo_back;
   assign hi_full   = cfg.circ * kilo_ff;
   assign frac_full = frac_prod_ff * FRAC_RECIP;

   always_comb begin
      rise = (func == FUNC_RISE) || ((func == FUNC_POLL) && button_level && !held_ff);
   end

   // event and revolution state
   always_comb begin
      ltt_in   = ltt_ff;
      let_in   = let_ff;
      lpt_in   = lpt_ff;
      rt_in    = rt_ff;
      ride_in  = ride_ff;
      count_in = count_ff;
      held_in  = held_ff;
      now_in   = now_ff;
      if (cmd.take) begin
         now_in = now_ms;
         if (rise) begin
            ltt_in = now_ms;
            if (since_trans > {16'b0, cfg.debounce}) begin
               let_in = now_ms;
            end
         end
         if (func == FUNC_FALL) begin
            ltt_in = now_ms;
         end
         if (func == FUNC_POLL) begin
            held_in = button_level;
         end
      end
      if (cmd.pulse && (let_ff != lpt_ff)) begin
         rt_in  = rev_span;
         lpt_in = let_ff;
         if (rev_span <= {16'b0, cfg.window}) begin
            ride_in  = ride_ff + rev_span;
            count_in = count_ff + 32'd1;
         end
      end
   end

   // operand preparation
   always_comb begin
      delta_in      = delta_ff;
      speed_ok_in   = speed_ok_ff;
      prod_speed_in = prod_speed_ff;
      scaled_in     = scaled_ff;
      kilo_in       = kilo_ff;
      kilo_rem_in   = kilo_rem_ff;
      dist_hi_in    = dist_hi_ff;
      frac_prod_in  = frac_prod_ff;
      frac_in       = frac_ff;
      if (cmd.calc) begin
         delta_in      = delta[15:0];
         speed_ok_in   = (delta != 32'd0) && (delta <= {16'b0, cfg.window});
         prod_speed_in = SECS_PER_HOUR * cfg.circ;
         kilo_in       = kilo_full[60:38];
      end
      if (cmd.mul) begin
         scaled_in   = prod_speed_ff * count_ff;
         kilo_rem_in = kilo_left[9:0];
         dist_hi_in  = hi_full[31:0];
      end
      if (cmd.dst_low) begin
         frac_prod_in = cfg.circ * kilo_rem_ff;
      end
      if (cmd.dst_scale) begin
         frac_in = frac_full[52:36];
      end
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      divisor_in   = divisor_ff;
      speed_res_in = speed_res_ff;
      dist_res_in  = dist_res_ff;
      avg_res_in   = avg_res_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         case (cmd.div_op)
            DIV_SPEED: begin
               quo_in     = {prod_speed_ff, 36'b0};
               cnt_in     = DIV_BITS_SPEED;
               divisor_in = {16'b0, delta_ff};
            end
            DIV_AVG: begin
               quo_in     = {scaled_ff, 4'b0};
               cnt_in     = DIV_BITS_AVG;
               divisor_in = ride_ff;
            end
            default: begin
               quo_in     = '0;
               cnt_in     = '0;
               divisor_in = '0;
            end
         endcase
      end else if (cmd.div_step && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.div_capture) begin
         case (cmd.div_op)
            DIV_SPEED: speed_res_in = speed_ok_ff ? quo_ff[27:0] : '0;
            DIV_AVG:   avg_res_in   = (ride_ff != 32'd0) ? quo_ff[31:0] : '0;
            default: ;
         endcase
      end
      if (cmd.dst_sum) begin
         dist_res_in = dist_hi_ff + {15'd0, frac_ff};
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in = '{speed_m_per_h: speed_res_ff, ride_time_ms: ride_ff,
                    distance_m: dist_res_ff, average_speed: avg_res_ff,
                    revolutions: count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ltt_ff   <= '0;
         let_ff   <= '0;
         lpt_ff   <= '0;
         rt_ff    <= '0;
         ride_ff  <= '0;
         count_ff <= '0;
         held_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         ltt_ff   <= ltt_in;
         let_ff   <= let_in;
         lpt_ff   <= lpt_in;
         rt_ff    <= rt_in;
         ride_ff  <= ride_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      delta_ff      <= delta_in;
      speed_ok_ff   <= speed_ok_in;
      prod_speed_ff <= prod_speed_in;
      scaled_ff     <= scaled_in;
      kilo_ff       <= kilo_in;
      kilo_rem_ff   <= kilo_rem_in;
      dist_hi_ff    <= dist_hi_in;
      frac_prod_ff  <= frac_prod_in;
      frac_ff       <= frac_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      divisor_ff    <= divisor_in;
      speed_res_ff  <= speed_res_in;
      dist_res_ff   <= dist_res_in;
      avg_res_ff    <= avg_res_in;
      rsp_ff        <= rsp_in;
   end

   assign status.div_busy = (cnt_ff != '0);
   assign rsp_data        = rsp_ff;

   `WPS_ASSERT_NEXT(a_load_busy, cmd.div_load, status.div_busy, "divider idle after load")
   `WPS_ASSERT_NOW(a_capture_done, cmd.div_capture, !status.div_busy, "capture while dividing")
   `WPS_ASSERT_NEXT(a_pulse_counts, cmd.pulse && (let_ff != lpt_ff), lpt_ff == $past(let_ff),
      "pulse time not taken")

endmodule

`default_nettype wire

/* rtl/wps_ctrl.sv */
// Controller of the wheel pulse speedometer: sequences event intake,
// preparation, the divisions, the distance scaling and the result beat. Depends on wps_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_pulse_speedometer_defines.svh"

module wps_ctrl
   import wps_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_func,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_func == FUNC_POLL) begin
                  state_in = ST_PULSE;
               end
            end
         end
         ST_PULSE: begin
            cmd.pulse = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SPD_LOAD;
         end
         ST_SPD_LOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_op   = DIV_SPEED;
            state_in     = ST_SPD_RUN;
         end
         ST_SPD_RUN: begin
            cmd.div_op = DIV_SPEED;
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.div_capture = 1'b1;
               state_in        = ST_DST_LOW;
            end
         end
         ST_DST_LOW: begin
            cmd.dst_low = 1'b1;
            state_in    = ST_DST_SCALE;
         end
         ST_DST_SCALE: begin
            cmd.dst_scale = 1'b1;
            state_in      = ST_DST_SUM;
         end
         ST_DST_SUM: begin
            cmd.dst_sum = 1'b1;
            state_in    = ST_AVG_LOAD;
         end
         ST_AVG_LOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_op   = DIV_AVG;
            state_in     = ST_AVG_RUN;
         end
         ST_AVG_RUN: begin
            cmd.div_op = DIV_AVG;
            if (status.div_busy) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.div_capture = 1'b1;
               state_in        = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   `WPS_ASSERT_NEXT(a_poll_starts, (state_ff == ST_IDLE) && req_valid && (req_func == FUNC_POLL),
      state_ff == ST_PULSE, "poll did not start a measurement")
   `WPS_ASSERT_NEXT(a_resp_beat, cmd.rsp_load, rsp_valid_ff && (state_ff == ST_IDLE),
      "result beat not raised")
   `WPS_ASSERT_NEXT(a_div_hold, (state_ff == ST_AVG_RUN) && status.div_busy,
      state_ff == ST_AVG_RUN, "left division early")

endmodule

`default_nettype wire

/* rtl/wheel_pulse_speedometer.sv */
// Top level of the wheel pulse speedometer: configuration registers,
// controller and datapath. Depends on wps_pkg, wps_if, wps_csr, wps_ctrl and wps_dp.
`timescale 1ns / 1ps
`default_nettype none

// Sensor rising and falling edges and odd function codes leave the controller in idle: the block is
// ready again in the next cycle. An update poll runs the single restoring divider, which
// produces one quotient bit a cycle for the speed (28 bits) and the average speed (60 bits)
// in turn; between the two divisions the distance is formed by reciprocal multiplication.
// A finished result sits in an output register, so the next event is taken while it waits;
// a further poll holds its result until the previous one has been taken.

module wheel_pulse_speedometer
   import wps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   wps_req_if.sink                    req_chan,
   wps_rsp_if.source                  rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output      logic [31:0]           prdata,
   output      logic                  pready
);

   cfg_type      cfg;
   cmd_type      cmd;
   status_type   status;
   rsp_data_type rsp_data;

   wps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wps_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .func         (req_chan.func),
      .now_ms       (req_chan.now_ms),
      .button_level (req_chan.button_level),
      .status       (status),
      .rsp_data     (rsp_data)
   );

   assign rsp_chan.speed_m_per_h = rsp_data.speed_m_per_h;
   assign rsp_chan.ride_time_ms  = rsp_data.ride_time_ms;
   assign rsp_chan.distance_m    = rsp_data.distance_m;
   assign rsp_chan.average_speed = rsp_data.average_speed;
   assign rsp_chan.revolutions   = rsp_data.revolutions;

endmodule

`default_nettype wire
